/* hw/rtl/qufp_pkg.sv */
`default_nettype none

package qufp_pkg;

    localparam int CNT_W = 12;
    localparam int SUM_W = CNT_W + 2;
    localparam logic [CNT_W-1:0] MAX_URI_LENGTH = 12'd4095;
    localparam logic [CNT_W-1:0] NAME_LIMIT_RESET = 12'd64;

    localparam logic [2:0] PH_SCHEME = 3'd0;
    localparam logic [2:0] PH_DOMAIN = 3'd1;
    localparam logic [2:0] PH_TIER   = 3'd2;
    localparam logic [2:0] PH_PATH   = 3'd3;
    localparam logic [2:0] PH_KEY    = 3'd4;
    localparam logic [2:0] PH_VALUE  = 3'd5;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_SCHEME = 3'd1;
    localparam logic [2:0] ST_DOMAIN = 3'd2;
    localparam logic [2:0] ST_TIER   = 3'd3;
    localparam logic [2:0] ST_QUEUE  = 3'd4;
    localparam logic [2:0] ST_CHAR   = 3'd5;
    localparam logic [2:0] ST_QUERY  = 3'd6;
    localparam logic [2:0] ST_LONG   = 3'd7;

    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_TILDE = 8'h7e;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_QMARK = 8'h3f;
    localparam logic [7:0] CH_EQUAL = 8'h3d;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CH_DASH  = 8'h2d;

    localparam logic [CNT_W-1:0] SCHEME_LEN = 12'd6;

    function automatic logic [7:0] scheme_char(input logic [CNT_W-1:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (pos)
            12'd0:   c = 8'h62;
            12'd1:   c = 8'h6d;
            12'd2:   c = 8'h71;
            12'd3:   c = 8'h3a;
            12'd4:   c = 8'h2f;
            12'd5:   c = 8'h2f;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] key_char(input logic [CNT_W-1:0] idx);
        logic [7:0] c;
        c = 8'h00;
        case (idx)
            12'd0:   c = 8'h69;
            12'd1:   c = 8'h64;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_plain(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a)
            || (c >= 8'h30 && c <= 8'h39) || c == CH_DASH;
    endfunction

    function automatic logic is_wide(input logic [7:0] c);
        return is_plain(c) || c == CH_UNDER || c == CH_DOT;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
        return (x < MAX_URI_LENGTH) ? x + 12'd1 : x;
    endfunction

    function automatic logic [CNT_W-1:0] sat_cap(input logic [SUM_W-1:0] x);
        return (x < {2'b00, MAX_URI_LENGTH}) ? x[CNT_W-1:0] : MAX_URI_LENGTH;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/queue_uri_field_parser.sv */
// queue uri field parser
// Input channel: one URI byte per transfer on ch, with last set on the final
// byte. A transfer happens at a clock edge with in_valid high and in_stall low.
// Output channel: one result per URI (status, the domain length, and start and
// length of the tier, path and id value), moved when out_valid is high and
// out_stall is low. All part fields read zero when status is not ok.
// Throughput is one byte per clock while in_stall is low: the parse state and
// the result are updated by a single pass of compare and add logic each cycle.
// Latency: the result is registered and appears the cycle after the last byte
// is taken.
// When the receiver stalls, bytes that are not last are still taken; a last
// byte is held off by in_stall until the waiting result has been moved.
// cfg_wr_en with cfg_wr_data sets the path length limit; write only while idle.
// Reset clears the parse state, drops any pending result and sets the limit
// to 64.
`default_nettype none

module queue_uri_field_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [11:0] cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  ch,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [11:0]      domain_length,
    output logic             has_tier,
    output logic [11:0]      tier_start,
    output logic [11:0]      tier_length,
    output logic [11:0]      path_start,
    output logic [11:0]      path_length,
    output logic             has_query,
    output logic [11:0]      id_start,
    output logic [11:0]      id_length
);
    import qufp_pkg::*;

    logic [CNT_W-1:0] limit_reg;
    logic [CNT_W-1:0] position_reg, position_next;
    logic [2:0]       phase_reg, phase_next;
    logic             dot_reg, dot_next;
    logic [2:0]       err_reg, err_next;
    logic [CNT_W-1:0] dom_reg, dom_next;
    logic [CNT_W-1:0] tier_reg, tier_next;
    logic [CNT_W-1:0] path_reg, path_next;
    logic [CNT_W-1:0] key_reg, key_next;
    logic             keym_reg, keym_next;
    logic [CNT_W-1:0] val_reg, val_next;

    logic             out_valid_reg, out_valid_next;
    logic [2:0]       status_reg, status_next;
    logic [11:0]      domain_length_reg, domain_length_next;
    logic             has_tier_reg, has_tier_next;
    logic [11:0]      tier_start_reg, tier_start_next;
    logic [11:0]      tier_length_reg, tier_length_next;
    logic [11:0]      path_start_reg, path_start_next;
    logic [11:0]      path_length_reg, path_length_next;
    logic             has_query_reg, has_query_next;
    logic [11:0]      id_start_reg, id_start_next;
    logic [11:0]      id_length_reg, id_length_next;

    logic             in_xfer;
    logic             tilde_taken;
    logic [SUM_W-1:0] auth_sum;
    logic [CNT_W-1:0] pstart;

    assign in_stall = out_valid_reg && out_stall && last;
    assign in_xfer  = in_valid && !in_stall;

    // byte walk
    always_comb
    begin
        position_next = sat_inc(position_reg);
        phase_next    = phase_reg;
        dot_next      = dot_reg;
        err_next      = err_reg;
        dom_next      = dom_reg;
        tier_next     = tier_reg;
        path_next     = path_reg;
        key_next      = key_reg;
        keym_next     = keym_reg;
        val_next      = val_reg;
        tilde_taken   = 1'b0;
        if (err_reg == ST_OK)
        begin
            unique case (phase_reg)
                PH_SCHEME:
                begin
                    if (position_reg < SCHEME_LEN && ch == scheme_char(position_reg))
                    begin
                        if (position_reg == 12'd5)
                            phase_next = PH_DOMAIN;
                    end
                    else
                        err_next = ST_SCHEME;
                end
                PH_DOMAIN:
                begin
                    if (dot_reg)
                    begin
                        dot_next = 1'b0;
                        if (ch == CH_TILDE)
                        begin
                            tilde_taken = 1'b1;
                            if (dom_reg == '0)
                                err_next = ST_DOMAIN;
                            else
                                phase_next = PH_TIER;
                        end
                        else
                            dom_next = sat_inc(dom_reg);
                    end
                    if (!tilde_taken)
                    begin
                        if (ch == CH_DOT)
                            dot_next = 1'b1;
                        else if (is_plain(ch) || ch == CH_UNDER)
                            dom_next = sat_inc(dom_next);
                        else if (ch == CH_SLASH)
                        begin
                            if (dom_next == '0)
                                err_next = ST_DOMAIN;
                            else
                                phase_next = PH_PATH;
                        end
                        else
                            err_next = ST_CHAR;
                    end
                end
                PH_TIER:
                begin
                    if (is_plain(ch))
                        tier_next = sat_inc(tier_reg);
                    else if (ch == CH_SLASH)
                    begin
                        if (tier_reg == '0)
                            err_next = ST_TIER;
                        else
                            phase_next = PH_PATH;
                    end
                    else
                        err_next = ST_CHAR;
                end
                PH_PATH:
                begin
                    if (is_wide(ch))
                        path_next = sat_inc(path_reg);
                    else if (ch == CH_QMARK)
                    begin
                        if (path_reg == '0)
                            err_next = ST_QUEUE;
                        else
                            phase_next = PH_KEY;
                    end
                    else
                        err_next = ST_CHAR;
                end
                PH_KEY:
                begin
                    if (ch == CH_EQUAL)
                    begin
                        if (keym_reg && key_reg == 12'd2)
                            phase_next = PH_VALUE;
                        else
                            err_next = ST_QUERY;
                    end
                    else
                    begin
                        if (key_reg >= 12'd2 || ch != key_char(key_reg))
                            keym_next = 1'b0;
                        key_next = sat_inc(key_reg);
                    end
                end
                default:
                begin
                    if (is_wide(ch))
                        val_next = sat_inc(val_reg);
                    else
                        err_next = ST_CHAR;
                end
            endcase
        end
    end

    // end of uri result
    always_comb
    begin
        if (err_next != ST_OK)
            status_next = err_next;
        else
        begin
            unique case (phase_next)
                PH_SCHEME: status_next = ST_SCHEME;
                PH_DOMAIN: status_next = (dom_next == '0 && !dot_next) ? ST_DOMAIN : ST_QUEUE;
                PH_TIER:   status_next = (tier_next == '0) ? ST_TIER : ST_QUEUE;
                PH_PATH:   status_next = (path_next == '0) ? ST_QUEUE
                                       : (path_next > limit_reg) ? ST_LONG : ST_OK;
                PH_KEY:    status_next = ST_QUERY;
                default:   status_next = (val_next == '0) ? ST_QUERY
                                       : (path_next > limit_reg) ? ST_LONG : ST_OK;
            endcase
        end

        auth_sum = {2'b00, dom_next}
                 + ((tier_next != '0) ? ({2'b00, tier_next} + 14'd2) : 14'd0);
        pstart   = sat_cap(auth_sum + 14'd7);

        domain_length_next = '0;
        has_tier_next      = 1'b0;
        tier_start_next    = '0;
        tier_length_next   = '0;
        path_start_next    = '0;
        path_length_next   = '0;
        has_query_next     = 1'b0;
        id_start_next      = '0;
        id_length_next     = '0;
        if (status_next == ST_OK)
        begin
            domain_length_next = dom_next;
            if (tier_next != '0)
            begin
                has_tier_next    = 1'b1;
                tier_start_next  = sat_cap({2'b00, dom_next} + 14'd8);
                tier_length_next = tier_next;
            end
            path_start_next  = pstart;
            path_length_next = path_next;
            if (val_next != '0)
            begin
                has_query_next = 1'b1;
                id_start_next  = sat_cap({2'b00, pstart} + {2'b00, path_next} + 14'd4);
                id_length_next = val_next;
            end
        end
    end

    assign out_valid_next = (in_xfer && last) || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= NAME_LIMIT_RESET;
            position_reg  <= '0;
            phase_reg     <= PH_SCHEME;
            dot_reg       <= 1'b0;
            err_reg       <= ST_OK;
            dom_reg       <= '0;
            tier_reg      <= '0;
            path_reg      <= '0;
            key_reg       <= '0;
            keym_reg      <= 1'b1;
            val_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;
            out_valid_reg <= out_valid_next;
            if (in_xfer)
            begin
                if (last)
                begin
                    position_reg <= '0;
                    phase_reg    <= PH_SCHEME;
                    dot_reg      <= 1'b0;
                    err_reg      <= ST_OK;
                    dom_reg      <= '0;
                    tier_reg     <= '0;
                    path_reg     <= '0;
                    key_reg      <= '0;
                    keym_reg     <= 1'b1;
                    val_reg      <= '0;
                end
                else
                begin
                    position_reg <= position_next;
                    phase_reg    <= phase_next;
                    dot_reg      <= dot_next;
                    err_reg      <= err_next;
                    dom_reg      <= dom_next;
                    tier_reg     <= tier_next;
                    path_reg     <= path_next;
                    key_reg      <= key_next;
                    keym_reg     <= keym_next;
                    val_reg      <= val_next;
                end
            end
        end
    end

    // result register, loaded when no result is held or the held one is moved
    always_ff @(posedge clk)
    begin
        if (in_xfer && last)
        begin
            status_reg        <= status_next;
            domain_length_reg <= domain_length_next;
            has_tier_reg      <= has_tier_next;
            tier_start_reg    <= tier_start_next;
            tier_length_reg   <= tier_length_next;
            path_start_reg    <= path_start_next;
            path_length_reg   <= path_length_next;
            has_query_reg     <= has_query_next;
            id_start_reg      <= id_start_next;
            id_length_reg     <= id_length_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign domain_length = domain_length_reg;
    assign has_tier      = has_tier_reg;
    assign tier_start    = tier_start_reg;
    assign tier_length   = tier_length_reg;
    assign path_start    = path_start_reg;
    assign path_length   = path_length_reg;
    assign has_query     = has_query_reg;
    assign id_start      = id_start_reg;
    assign id_length     = id_length_reg;

endmodule

`default_nettype wire
